[rtl/mbsp_pkg.sv]
// Shared types, message kind codes and helper functions for the MIDI byte stream parser.
package mbsp_pkg;

  localparam logic [4:0] KIND_NOTE_OFF = 5'd0;
  localparam logic [4:0] KIND_NOTE_ON  = 5'd1;
  localparam logic [4:0] KIND_POLY_AT  = 5'd2;
  localparam logic [4:0] KIND_CTRL     = 5'd3;
  localparam logic [4:0] KIND_PROG     = 5'd4;
  localparam logic [4:0] KIND_CHAN_AT  = 5'd5;
  localparam logic [4:0] KIND_BEND     = 5'd6;
  localparam logic [4:0] KIND_SYSEX    = 5'd7;
  localparam logic [4:0] KIND_QFRAME   = 5'd8;
  localparam logic [4:0] KIND_SONGPOS  = 5'd9;
  localparam logic [4:0] KIND_SONGSEL  = 5'd10;
  localparam logic [4:0] KIND_TUNE     = 5'd11;
  localparam logic [4:0] KIND_CLOCK    = 5'd12;
  localparam logic [4:0] KIND_START    = 5'd13;
  localparam logic [4:0] KIND_CONT     = 5'd14;
  localparam logic [4:0] KIND_STOP     = 5'd15;
  localparam logic [4:0] KIND_SENSE    = 5'd16;
  localparam logic [4:0] KIND_RESET    = 5'd17;

  localparam logic [4:0] SYS_CHANNEL = 5'd16;
  localparam logic [4:0] KEY_LIMIT   = 5'd20;

  // low nibble codes of system common status bytes
  localparam logic [3:0] SC_SYSEX   = 4'h0;
  localparam logic [3:0] SC_QFRAME  = 4'h1;
  localparam logic [3:0] SC_SONGPOS = 4'h2;
  localparam logic [3:0] SC_SONGSEL = 4'h3;
  localparam logic [3:0] SC_TUNE    = 4'h6;

  // low three bits of real-time status bytes
  localparam logic [2:0] RT_CLOCK = 3'd0;
  localparam logic [2:0] RT_UNDEF_A = 3'd1;
  localparam logic [2:0] RT_START = 3'd2;
  localparam logic [2:0] RT_CONT  = 3'd3;
  localparam logic [2:0] RT_STOP  = 3'd4;
  localparam logic [2:0] RT_UNDEF_B = 3'd5;
  localparam logic [2:0] RT_SENSE = 3'd6;
  localparam logic [2:0] RT_RESET = 3'd7;

  typedef struct packed {
    logic [4:0]        message_kind;
    logic [4:0]        channel_number;
    logic [6:0]        first_data;
    logic [6:0]        second_data;
    logic signed [13:0] bend_amount;
    logic [13:0]       song_position;
    logic [2:0]        frame_piece;
    logic [3:0]        frame_nibble;
    logic [4:0]        keys_held;
  } result_t;

  function automatic logic [4:0] rt_kind(input logic [2:0] idx);
    logic [4:0] k;
    case (idx)
      RT_START: k = KIND_START;
      RT_CONT:  k = KIND_CONT;
      RT_STOP:  k = KIND_STOP;
      RT_SENSE: k = KIND_SENSE;
      RT_RESET: k = KIND_RESET;
      default:  k = KIND_CLOCK;
    endcase
    return k;
  endfunction

  function automatic result_t make_result(input logic [4:0] kind, input logic [4:0] chan,
                                          input logic [6:0] d1, input logic [6:0] d2,
                                          input logic [4:0] keys);
    result_t    r;
    logic [13:0] comb;
    comb = {d2, d1};
    r.message_kind   = kind;
    r.channel_number = chan;
    r.first_data     = d1;
    r.second_data    = d2;
    // minus 8192 modulo 2^14 flips the top bit
    r.bend_amount    = (kind == KIND_BEND) ? signed'(comb ^ 14'h2000) : 14'sd0;
    r.song_position  = (kind == KIND_SONGPOS) ? comb : 14'd0;
    r.frame_piece    = (kind == KIND_QFRAME) ? d1[6:4] : 3'd0;
    r.frame_nibble   = (kind == KIND_QFRAME) ? d1[3:0] : 4'd0;
    r.keys_held      = keys;
    return r;
  endfunction

endpackage

[rtl/mbsp_ifs.sv]
// Handshake interfaces for the byte input, result output and configuration write channels.
interface mbsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mbsp_result_if;
  logic               valid;
  logic               ready;
  logic [4:0]         message_kind;
  logic [4:0]         channel_number;
  logic [6:0]         first_data;
  logic [6:0]         second_data;
  logic signed [13:0] bend_amount;
  logic [13:0]        song_position;
  logic [2:0]         frame_piece;
  logic [3:0]         frame_nibble;
  logic [4:0]         keys_held;
  modport source (output valid, output message_kind, output channel_number,
                  output first_data, output second_data, output bend_amount,
                  output song_position, output frame_piece, output frame_nibble,
                  output keys_held, input ready);
  modport sink   (input valid, input message_kind, input channel_number,
                  input first_data, input second_data, input bend_amount,
                  input song_position, input frame_piece, input frame_nibble,
                  input keys_held, output ready);
endinterface

interface mbsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] listen_channel;
  modport source (output valid, output listen_channel, input ready);
  modport sink   (input valid, input listen_channel, output ready);
endinterface

[rtl/mbsp_parser.sv]
// Parser state and single-step decode of one MIDI byte into an optional result word.
module mbsp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  input  logic [4:0]           listen,
  output logic                 res_valid,
  output mbsp_pkg::result_t    res
);

  logic [4:0] kind_r, kind_nxt;
  logic       kind_valid_r, kind_valid_nxt;
  logic [4:0] chan_r, chan_nxt;
  logic [1:0] exp_r, exp_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic [6:0] d1_r, d1_nxt;
  logic [6:0] d2_r, d2_nxt;
  logic       discard_r, discard_nxt;
  logic [4:0] keys_r, keys_nxt;

  always_comb begin
    logic       fin;
    logic       go;
    logic       pass;
    logic [6:0] o1;
    logic [6:0] o2;
    kind_nxt       = kind_r;
    kind_valid_nxt = kind_valid_r;
    chan_nxt       = chan_r;
    exp_nxt        = exp_r;
    rem_nxt        = rem_r;
    d1_nxt         = d1_r;
    d2_nxt         = d2_r;
    discard_nxt    = discard_r;
    keys_nxt       = keys_r;
    res_valid      = 1'b0;
    res            = mbsp_pkg::make_result(mbsp_pkg::KIND_CLOCK, mbsp_pkg::SYS_CHANNEL,
                                           7'd0, 7'd0, keys_r);
    fin            = 1'b0;
    go             = 1'b0;
    pass           = 1'b1;
    o1             = 7'd0;
    o2             = 7'd0;

    if (byte_in[7]) begin
      if (byte_in[6:3] == 4'b1111) begin
        // real-time: leaves message in progress untouched
        if (byte_in[2:0] != mbsp_pkg::RT_UNDEF_A && byte_in[2:0] != mbsp_pkg::RT_UNDEF_B) begin
          res_valid = 1'b1;
          res = mbsp_pkg::make_result(mbsp_pkg::rt_kind(byte_in[2:0]), mbsp_pkg::SYS_CHANNEL,
                                      7'd0, 7'd0, keys_r);
        end
      end else begin
        d1_nxt         = 7'd0;
        d2_nxt         = 7'd0;
        discard_nxt    = 1'b0;
        kind_valid_nxt = 1'b1;
        fin            = 1'b1;
        if (byte_in[6:4] != 3'b111) begin
          kind_nxt = {2'b00, byte_in[6:4]};
          chan_nxt = {1'b0, byte_in[3:0]};
          exp_nxt  = (kind_nxt == mbsp_pkg::KIND_PROG || kind_nxt == mbsp_pkg::KIND_CHAN_AT)
                     ? 2'd1 : 2'd2;
        end else begin
          chan_nxt = mbsp_pkg::SYS_CHANNEL;
          unique case (byte_in[3:0])
            mbsp_pkg::SC_SYSEX:   begin kind_nxt = mbsp_pkg::KIND_SYSEX;   exp_nxt = 2'd0; end
            mbsp_pkg::SC_QFRAME:  begin kind_nxt = mbsp_pkg::KIND_QFRAME;  exp_nxt = 2'd1; end
            mbsp_pkg::SC_SONGPOS: begin kind_nxt = mbsp_pkg::KIND_SONGPOS; exp_nxt = 2'd2; end
            mbsp_pkg::SC_SONGSEL: begin kind_nxt = mbsp_pkg::KIND_SONGSEL; exp_nxt = 2'd1; end
            mbsp_pkg::SC_TUNE:    begin kind_nxt = mbsp_pkg::KIND_TUNE;    exp_nxt = 2'd0; end
            default: begin
              kind_valid_nxt = 1'b0;
              discard_nxt    = 1'b1;
              kind_nxt       = mbsp_pkg::KIND_NOTE_OFF;
              exp_nxt        = 2'd0;
              fin            = 1'b0;
            end
          endcase
        end
        rem_nxt = exp_nxt;
        if (exp_nxt != 2'd0) fin = 1'b0;
      end
    end else if (!discard_r && kind_valid_r) begin
      go = 1'b1;
      if (rem_r == 2'd0) begin
        if (kind_r <= mbsp_pkg::KIND_BEND && exp_r != 2'd0) begin
          rem_nxt = exp_r;
          d1_nxt  = 7'd0;
          d2_nxt  = 7'd0;
        end else begin
          discard_nxt = 1'b1;
          go          = 1'b0;
        end
      end
      if (go) begin
        if (rem_nxt == exp_r) d1_nxt = byte_in[6:0];
        else d2_nxt = byte_in[6:0];
        rem_nxt = rem_nxt - 2'd1;
        fin     = (rem_nxt == 2'd0);
      end
    end

    if (fin) begin
      o1 = (exp_nxt >= 2'd1) ? d1_nxt : 7'd0;
      o2 = (exp_nxt >= 2'd2) ? d2_nxt : 7'd0;
      if (kind_nxt <= mbsp_pkg::KIND_BEND) begin
        pass = listen[4] || (listen == chan_nxt);
        if (pass && kind_nxt == mbsp_pkg::KIND_NOTE_ON) begin
          keys_nxt = (keys_r >= mbsp_pkg::KEY_LIMIT) ? 5'd0 : keys_r + 5'd1;
        end else if (pass && kind_nxt == mbsp_pkg::KIND_NOTE_OFF) begin
          keys_nxt = (keys_r == 5'd0 || keys_r > mbsp_pkg::KEY_LIMIT) ? 5'd0 : keys_r - 5'd1;
        end
      end
      res_valid = pass;
      res = mbsp_pkg::make_result(kind_nxt, chan_nxt, o1, o2, keys_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= mbsp_pkg::KIND_NOTE_OFF;
      kind_valid_r <= 1'b0;
      chan_r       <= mbsp_pkg::SYS_CHANNEL;
      exp_r        <= 2'd0;
      rem_r        <= 2'd0;
      d1_r         <= 7'd0;
      d2_r         <= 7'd0;
      discard_r    <= 1'b1;
      keys_r       <= 5'd0;
    end else if (step) begin
      kind_r       <= kind_nxt;
      kind_valid_r <= kind_valid_nxt;
      chan_r       <= chan_nxt;
      exp_r        <= exp_nxt;
      rem_r        <= rem_nxt;
      d1_r         <= d1_nxt;
      d2_r         <= d2_nxt;
      discard_r    <= discard_nxt;
      keys_r       <= keys_nxt;
    end
  end

endmodule

[rtl/mbsp_skid.sv]
// Two-entry result buffer between the parser and the output channel.
module mbsp_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mbsp_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output mbsp_pkg::result_t out_data
);

  mbsp_pkg::result_t ent_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_r, rd_r;
  logic       pop;

  assign room      = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = ent_r[rd_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_data;
  end

endmodule

[rtl/midi_byte_stream_parser.sv]
// Top level of the MIDI byte stream parser: input register, parser and result buffer.
// Usage:
//   in_byte    : one received MIDI byte per word; status bytes carry bit 7.
//   out_result : one word per completed message that passes the channel filter,
//                and one per real-time byte but 0xF9 and 0xFD; most bytes give no word at all.
//   cfg_write  : listen_channel, 0..15 to filter, 16 or more for all channels.
//                Always ready; write only while no bytes are in flight.
// Flow: a taken byte waits in the input register, is decoded there by the parser
//   once the result buffer has room, and its result word goes to out_result from it.
// Throughput: one byte per cycle; the decode is one pass over the parser state.
// A two-entry result buffer sits on the output, so in_byte stays ready while
//   one result waits. When the receiver stalls and the buffer fills, the
//   decode stage holds its byte and in_byte.ready drops until a word leaves.
// Reset: rst_n low, synchronous. Clears the running status (data bytes are
//   dropped until a status byte), the held-key count and the result buffer,
//   and sets listen_channel back to all channels.
module midi_byte_stream_parser (
  input  logic          clk,
  input  logic          rst_n,
  mbsp_byte_if.sink     in_byte,
  mbsp_result_if.source out_result,
  mbsp_cfg_if.sink      cfg_write
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic [4:0]        listen_r;
  logic              room;
  logic              step;
  logic              res_valid;
  mbsp_pkg::result_t res;
  mbsp_pkg::result_t out_data;

  assign step            = s1_valid_r && room;
  assign in_byte.ready   = !s1_valid_r || room;
  assign cfg_write.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      listen_r   <= mbsp_pkg::SYS_CHANNEL;
    end else begin
      if (in_byte.valid && in_byte.ready) s1_valid_r <= 1'b1;
      else if (step) s1_valid_r <= 1'b0;
      if (cfg_write.valid) listen_r <= cfg_write.listen_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) s1_byte_r <= in_byte.midi_byte;
  end

  mbsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (s1_byte_r),
    .listen    (listen_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mbsp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_result.valid),
    .out_ready (out_result.ready),
    .out_data  (out_data)
  );

  assign out_result.message_kind   = out_data.message_kind;
  assign out_result.channel_number = out_data.channel_number;
  assign out_result.first_data     = out_data.first_data;
  assign out_result.second_data    = out_data.second_data;
  assign out_result.bend_amount    = out_data.bend_amount;
  assign out_result.song_position  = out_data.song_position;
  assign out_result.frame_piece    = out_data.frame_piece;
  assign out_result.frame_nibble   = out_data.frame_nibble;
  assign out_result.keys_held      = out_data.keys_held;

endmodule

[rtl/mbsp_checker.sv]
// Port-level checks on the result channel of the parser, bound to the top level.
module mbsp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [4:0]         message_kind,
  input logic [4:0]         channel_number,
  input logic signed [13:0] bend_amount,
  input logic [4:0]         keys_held
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(message_kind) && $stable(keys_held))
    else $error("result word changed while stalled");

  a_sys_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((message_kind >= mbsp_pkg::KIND_SYSEX) ==
                   (channel_number == mbsp_pkg::SYS_CHANNEL)))
    else $error("channel number does not match message kind");

  a_key_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> keys_held <= mbsp_pkg::KEY_LIMIT)
    else $error("held key count above limit");

  a_bend_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_kind != mbsp_pkg::KIND_BEND |-> bend_amount == 14'sd0)
    else $error("bend amount set on a non-bend word");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_result.valid),
  .out_ready      (out_result.ready),
  .message_kind   (out_result.message_kind),
  .channel_number (out_result.channel_number),
  .bend_amount    (out_result.bend_amount),
  .keys_held      (out_result.keys_held)
);
